@@ rtl/trace_overflow_time_estimator_unit_assert.svh @@
// assertion macros for the trace overflow time estimator
`ifndef TRACE_OVERFLOW_TIME_ESTIMATOR_UNIT_ASSERT_SVH
`define TRACE_OVERFLOW_TIME_ESTIMATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define TOE_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define TOE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ rtl/toe_pkg.sv @@
// types, constants and codes shared by the trace overflow time estimator
package toe_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned TIME_W      = 64;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned DIVISOR_W   = $clog2(QUEUE_DEPTH + 2);
  localparam int unsigned DIV_STEPS   = TIME_W;
  localparam int unsigned STEP_W      = $clog2(DIV_STEPS);

  localparam logic [1:0] RANGE_RESET = 2'd3;
  localparam logic [7:0] FIELD_MASK  = 8'hff;

  typedef enum logic [1:0] {
    FUNC_TSC = 2'd0,
    FUNC_MTC = 2'd1,
    FUNC_OVF = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DIV,
    S_EST,
    S_MARG,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]        func;
    logic [TIME_W-1:0] tsc_value;
    logic [7:0]        mtc_value;
    logic [1:0]        mtc_range;
    logic [TIME_W-1:0] event_offset;
  } toe_in_t;

  typedef struct packed {
    logic              estimate_valid;
    logic [TIME_W-1:0] overflow_position;
    logic [TIME_W-1:0] estimated_time;
    logic [TIME_W-1:0] time_margin;
    logic              dropped_mtc;
    logic              queue_lost;
    logic              last;
  } toe_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

@@ rtl/toe_ram.sv @@
// generic single-port-write, registered-read memory
module toe_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/toe_div.sv @@
// bit-serial restoring divider, one quotient bit per cycle
module toe_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [toe_pkg::TIME_W-1:0]    dividend_i,
  input  logic [toe_pkg::DIVISOR_W-1:0] divisor_i,
  output logic [toe_pkg::TIME_W-1:0]    quotient_o,
  output toe_pkg::div_sts_t             sts_o
);
  import toe_pkg::*;

  logic [TIME_W-1:0]    work_q, work_d;
  logic [DIVISOR_W-1:0] rem_q, rem_d;
  logic [DIVISOR_W-1:0] divisor_q;
  logic [STEP_W-1:0]    step_q, step_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIVISOR_W:0]   shifted;
  logic [DIVISOR_W:0]   diff;
  logic                 ge;

  always_comb begin
    shifted = {rem_q, work_q[TIME_W-1]};
    diff    = shifted - {1'b0, divisor_q};
    ge      = shifted >= {1'b0, divisor_q};
    work_d  = work_q;
    rem_d   = rem_q;
    step_d  = step_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      work_d = dividend_i;
      rem_d  = '0;
      step_d = STEP_W'(DIV_STEPS - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      work_d = {work_q[TIME_W-2:0], ge};
      rem_d  = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      step_d = step_q - STEP_W'(1);
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    step_q <= step_d;
    if (start_i) begin
      divisor_q <= divisor_i;
    end
  end

  assign quotient_o = work_q;
  assign sts_o      = '{busy: busy_q, done: done_q};

endmodule

@@ rtl/trace_overflow_time_estimator_unit.sv @@
// top level of the trace overflow time estimator
// timestamp, mtc or overflow request taken only while idle
// overflow request: no result
// timestamp with empty queue: one result, registered in the cycle after the request
// per queued overflow: one result, via read, 64-step serial divide, estimate, margin and output states
// reset: queue empty, previous time 0, mtc range 3, lost flag clear
`include "trace_overflow_time_estimator_unit_assert.svh"

module trace_overflow_time_estimator_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  toe_pkg::toe_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output toe_pkg::toe_out_t out_data_o
);
  import toe_pkg::*;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [TIME_W-1:0] prev_q, prev_d;
  logic [1:0]        range_q, range_d;
  logic              lost_q, lost_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [TIME_W-1:0] t_q, t_d;
  logic [TIME_W-1:0] span_q, span_d;
  logic [TIME_W-1:0] prod_q, prod_d;
  logic [TIME_W-1:0] est_q, est_d;
  logic              dropped_q, dropped_d;
  logic              out_valid_q, out_valid_d;
  toe_out_t          out_q, out_d;

  logic              in_take;
  logic              out_take;
  logic [3:0]        mtc_shift;
  logic [3:0]        drop_shift;
  logic [7:0]        prev_field;
  logic [7:0]        new_field;
  logic [TIME_W-1:0] mtc_base;
  logic [TIME_W-1:0] mtc_time;
  logic [TIME_W-1:0] new_time;
  logic [7:0]        field_step;
  logic              drop_new;
  logic [TIME_W-1:0] b_dist;
  logic              ram_we;
  logic              ram_re;
  logic [TIME_W-1:0] ram_rdata;
  logic              div_start;
  logic [TIME_W-1:0] quotient;
  div_sts_t          div_sts;

  assign in_take  = in_valid_i && (state_q == S_IDLE);
  assign out_take = out_valid_q && !out_stall_i;

  // mtc reconstruction against the previous time
  always_comb begin
    mtc_shift  = 4'd7 + {1'b0, in_data_i.mtc_range, 1'b0};
    prev_field = 8'((prev_q >> mtc_shift) & TIME_W'(FIELD_MASK));
    mtc_base   = prev_q;
    if (prev_field > in_data_i.mtc_value) begin
      mtc_base = prev_q + (TIME_W'(9'h100) << mtc_shift);
    end
    mtc_time = (mtc_base & ({TIME_W{1'b1}} << ({1'b0, mtc_shift} + 5'd8)))
             | (TIME_W'(in_data_i.mtc_value) << mtc_shift);
    new_time = (in_data_i.func == FUNC_MTC) ? mtc_time : in_data_i.tsc_value;
  end

  // dropped tick check at the range in force after this request
  always_comb begin
    drop_shift = (in_data_i.func == FUNC_MTC)
               ? 4'd7 + {1'b0, in_data_i.mtc_range, 1'b0}
               : 4'd7 + {1'b0, range_q, 1'b0};
    new_field  = 8'((new_time >> drop_shift) & TIME_W'(FIELD_MASK));
    field_step = new_field - 8'((prev_q >> drop_shift) & TIME_W'(FIELD_MASK));
    drop_new   = field_step > 8'd1;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    prev_d      = prev_q;
    range_d     = range_q;
    lost_d      = lost_q;
    idx_d       = idx_q;
    t_d         = t_q;
    span_d      = span_q;
    prod_d      = prod_q;
    est_d       = est_q;
    dropped_d   = dropped_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    div_start   = 1'b0;
    b_dist      = t_q - est_q;
    case (state_q)
      S_IDLE: begin
        if (in_take) begin
          case (in_data_i.func)
            FUNC_TSC, FUNC_MTC: begin
              if (in_data_i.func == FUNC_MTC) begin
                range_d = in_data_i.mtc_range;
              end
              t_d       = new_time;
              span_d    = new_time - prev_q;
              prod_d    = new_time - prev_q;
              idx_d     = '0;
              dropped_d = drop_new;
              if (count_q == '0) begin
                out_valid_d = 1'b1;
                out_d       = '{estimate_valid: 1'b0, overflow_position: '0,
                                estimated_time: '0, time_margin: '0,
                                dropped_mtc: drop_new, queue_lost: lost_q,
                                last: 1'b1};
                state_d     = S_OUT;
              end else begin
                state_d = S_READ;
              end
            end
            FUNC_OVF: begin
              if (count_q < CNT_W'(QUEUE_DEPTH)) begin
                ram_we  = 1'b1;
                count_d = count_q + CNT_W'(1);
              end else begin
                lost_d = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        ram_re    = 1'b1;
        div_start = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (div_sts.done) begin
          state_d = S_EST;
        end
      end
      S_EST: begin
        est_d   = prev_q + quotient;
        state_d = S_MARG;
      end
      S_MARG: begin
        out_valid_d = 1'b1;
        out_d       = '{estimate_valid: 1'b1, overflow_position: ram_rdata,
                        estimated_time: est_q,
                        time_margin: (quotient > b_dist) ? quotient : b_dist,
                        dropped_mtc: dropped_q, queue_lost: lost_q,
                        last: (CNT_W'(idx_q) + CNT_W'(1)) == count_q};
        state_d     = S_OUT;
      end
      S_OUT: begin
        if (out_take) begin
          out_valid_d = 1'b0;
          if (out_q.last) begin
            count_d = '0;
            lost_d  = 1'b0;
            prev_d  = t_q;
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            prod_d  = prod_q + span_q;
            state_d = S_READ;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      prev_q      <= '0;
      range_q     <= RANGE_RESET;
      lost_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      prev_q      <= prev_d;
      range_q     <= range_d;
      lost_q      <= lost_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    t_q       <= t_d;
    span_q    <= span_d;
    prod_q    <= prod_d;
    est_q     <= est_d;
    dropped_q <= dropped_d;
    out_q     <= out_d;
  end

  toe_ram #(
    .WIDTH(TIME_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(count_q[IDX_W-1:0]),
    .wdata_i(in_data_i.event_offset),
    .re_i   (ram_re),
    .raddr_i(idx_q),
    .rdata_o(ram_rdata)
  );

  toe_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(prod_q),
    .divisor_i (DIVISOR_W'(count_q) + DIVISOR_W'(1)),
    .quotient_o(quotient),
    .sts_o     (div_sts)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `TOE_ASSERT_NOW(a_out_only_in_out, out_valid_q, state_q == S_OUT, "result outside output state")
  `TOE_ASSERT_NOW(a_div_done_in_div, div_sts.done, state_q == S_DIV, "divider done out of step")
  `TOE_ASSERT_NOW(a_idle_div_quiet, state_q == S_IDLE, !div_sts.busy, "divider busy while idle")
  `TOE_ASSERT_NEXT(a_finish_clears, out_take && out_q.last,
                   count_q == '0 && !lost_q && state_q == S_IDLE, "queue not cleared at finish")

endmodule

@@ tb/toe_checker.sv @@
// checker for the trace overflow time estimator: predicts results and compares them
`timescale 1ns / 1ps

module toe_checker
  import toe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  toe_in_t     in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  toe_out_t    out_data_i,
  output int unsigned fail_count_o,
  output int unsigned awaited_o
);

  logic [TIME_W-1:0] queued_offsets [QUEUE_DEPTH];
  int unsigned       queued_count;
  logic [TIME_W-1:0] last_time;
  logic [1:0]        mtc_range_q;
  logic              overflow_lost;
  toe_out_t          awaited_results [$];
  int unsigned       mismatches = 0;

  task automatic compare_field(input string name, input logic [TIME_W-1:0] want,
                               input logic [TIME_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic take_new_time(input logic [TIME_W-1:0] new_time);
    int unsigned       shift;
    int unsigned       idx;
    logic [7:0]        new_field;
    logic [7:0]        old_field;
    logic [7:0]        field_step;
    logic [TIME_W-1:0] span;
    logic [TIME_W-1:0] divisor;
    logic [TIME_W-1:0] scaled;
    logic [TIME_W-1:0] estimate;
    logic [TIME_W-1:0] below;
    logic [TIME_W-1:0] above;
    toe_out_t          res;
    shift      = 7 + 2 * 32'(mtc_range_q);
    new_field  = 8'(new_time >> shift);
    old_field  = 8'(last_time >> shift);
    field_step = new_field - old_field;
    res = '0;
    res.dropped_mtc = (field_step > 8'd1);
    res.queue_lost  = overflow_lost;
    if (queued_count == 0) begin
      res.last = 1'b1;
      awaited_results.insert(awaited_results.size(), res);
    end else begin
      span    = new_time - last_time;
      divisor = 64'(queued_count + 1);
      for (idx = 0; idx < queued_count; idx++) begin
        scaled   = span * 64'(idx + 1);
        estimate = last_time + scaled / divisor;
        below    = estimate - last_time;
        above    = new_time - estimate;
        res.estimate_valid    = 1'b1;
        res.overflow_position = queued_offsets[idx];
        res.estimated_time    = estimate;
        res.time_margin       = (below > above) ? below : above;
        res.last              = (idx + 1 == queued_count);
        awaited_results.insert(awaited_results.size(), res);
      end
      queued_count = 0;
    end
    overflow_lost = 1'b0;
    last_time     = new_time;
  endtask

  task automatic take_request(input toe_in_t req);
    int unsigned       shift;
    logic [TIME_W-1:0] rebuilt;
    case (req.func)
      FUNC_TSC: begin
        take_new_time(req.tsc_value);
      end
      FUNC_MTC: begin
        mtc_range_q = req.mtc_range;
        shift   = 7 + 2 * 32'(mtc_range_q);
        rebuilt = last_time;
        if (8'(last_time >> shift) > req.mtc_value) begin
          rebuilt = rebuilt + (64'h100 << shift);
        end
        rebuilt = (rebuilt & ({TIME_W{1'b1}} << (shift + 8))) | (64'(req.mtc_value) << shift);
        take_new_time(rebuilt);
      end
      FUNC_OVF: begin
        if (queued_count < QUEUE_DEPTH) begin
          queued_offsets[queued_count] = req.event_offset;
          queued_count++;
        end else begin
          overflow_lost = 1'b1;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_result(input toe_out_t got);
    toe_out_t want;
    if (awaited_results.size() == 0) begin
      $error("result with nothing awaited: %h", got);
      mismatches++;
    end else begin
      want = awaited_results.pop_front();
      compare_field("estimate_valid", 64'(want.estimate_valid), 64'(got.estimate_valid));
      compare_field("overflow_position", want.overflow_position, got.overflow_position);
      compare_field("estimated_time", want.estimated_time, got.estimated_time);
      compare_field("time_margin", want.time_margin, got.time_margin);
      compare_field("dropped_mtc", 64'(want.dropped_mtc), 64'(got.dropped_mtc));
      compare_field("queue_lost", 64'(want.queue_lost), 64'(got.queue_lost));
      compare_field("last", 64'(want.last), 64'(got.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queued_count  = 0;
      last_time     = '0;
      mtc_range_q   = RANGE_RESET;
      overflow_lost = 1'b0;
      awaited_results.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        take_request(in_data_i);
      end
      if (out_valid_i && !out_stall_i) begin
        check_result(out_data_i);
      end
    end
    awaited_o    <= awaited_results.size();
    fail_count_o <= mismatches;
  end

endmodule

@@ tb/testbench.sv @@
// top of the trace overflow time estimator testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module testbench;
  import toe_pkg::*;

  localparam logic [1:0]  FUNC_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned DRAIN_WAIT  = 100;
  localparam int unsigned PHASE_ITEMS = 75;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  toe_in_t     in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  toe_out_t    out_data_o;
  int unsigned fail_count;
  int unsigned awaited;

  int unsigned send_idle_pct  = 6;
  int unsigned recv_stall_pct = 74;
  int unsigned items_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned cycle_count    = 0;
  logic [7:0]  held_field     = '0;
  logic [1:0]  held_range     = RANGE_RESET;

  trace_overflow_time_estimator_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  toe_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .fail_count_o(fail_count),
    .awaited_o   (awaited)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    if (out_valid_o && !out_stall_i) begin
      results_seen <= results_seen + 1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic toe_in_t random_request(input logic [1:0] func);
    toe_in_t req;
    req.func         = func;
    req.tsc_value    = {$urandom, $urandom};
    req.mtc_value    = 8'($urandom);
    req.mtc_range    = 2'($urandom);
    req.event_offset = {$urandom, $urandom};
    return req;
  endfunction

  task automatic send_request(input toe_in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (req.func != FUNC_UNUSED) items_sent++;
  endtask

  // mtc packets continue the previous field half of the time so that dropped ticks are not the rule
  task automatic send_new_time();
    toe_in_t req;
    if ($urandom_range(3) == 0) begin
      req = random_request(FUNC_TSC);
    end else begin
      req = random_request(FUNC_MTC);
      if ($urandom_range(1) == 1) begin
        req.mtc_range = held_range;
        req.mtc_value = held_field + 8'd1;
      end
      held_range = req.mtc_range;
      held_field = req.mtc_value;
    end
    send_request(req);
  endtask

  initial begin
    toe_in_t     req;
    int unsigned burst;
    int unsigned phase_end;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // timestamp extremes, range 3 wrap to zero, unused code, overflow offset extremes
    req = random_request(FUNC_TSC);
    req.tsc_value = '1;
    send_request(req);
    req = random_request(FUNC_MTC);
    req.mtc_range = 2'd3;
    req.mtc_value = 8'd0;
    send_request(req);
    send_request(random_request(FUNC_UNUSED));
    req = random_request(FUNC_OVF);
    req.event_offset = '0;
    send_request(req);
    req = random_request(FUNC_OVF);
    req.event_offset = '1;
    send_request(req);
    req = random_request(FUNC_TSC);
    req.tsc_value = '0;
    send_request(req);
    // full queue with one overflow lost, closed by a range 0 mtc at the top field value
    repeat (QUEUE_DEPTH + 1) send_request(random_request(FUNC_OVF));
    req = random_request(FUNC_MTC);
    req.mtc_range = 2'd0;
    req.mtc_value = 8'hff;
    send_request(req);
    held_range = req.mtc_range;
    held_field = req.mtc_value;

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct  = (phase == 0) ? 6 : (phase == 1) ? 74 : 0;
      recv_stall_pct = (phase == 0) ? 74 : (phase == 1) ? 6 : 0;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        burst = ($urandom_range(9) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 3);
        repeat (burst) begin
          if ($urandom_range(19) == 0) send_request(random_request(FUNC_UNUSED));
          send_request(random_request(FUNC_OVF));
        end
        if ($urandom_range(7) == 0) send_request(random_request(FUNC_UNUSED));
        send_new_time();
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (awaited != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("%0d requests sent over three idling profiles, %0d results checked",
             items_sent, results_seen);
    if (fail_count == 0 && awaited == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
